// ----- rtl/kat_pkg.sv -----
package kat_pkg;

    localparam int NUM_KEYS = 256;
    localparam int KEY_W    = $clog2(NUM_KEYS);
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;

    localparam logic [CFG_W-1:0] DELAY_RESET    = CFG_W'(400);
    localparam logic [CFG_W-1:0] INTERVAL_RESET = CFG_W'(16);

    // configuration register indexes
    localparam logic [1:0] REG_DELAY    = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;

    typedef enum logic [1:0] {
        OP_EVENT = 2'd0,
        OP_TICK  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic type_pulse;
        logic repeating;
        logic changed;
        logic down;
    } flags_t;

    typedef struct packed {
        flags_t              flags;
        logic [TIME_W-1:0]   change_time;
        logic [TIME_W-1:0]   typed_time;
    } entry_t;

    typedef struct packed {
        logic key_down;
        logic key_pressed;
        logic key_released;
        logic should_type;
    } result_t;

endpackage

// ----- rtl/kat_entry_update.sv -----
module kat_entry_update
    import kat_pkg::*;
(
    input  entry_t             cur_entry,
    input  logic               is_tick,
    input  logic               level,
    input  logic [TIME_W-1:0]  now,
    input  logic [CFG_W-1:0]   repeat_delay,
    input  logic [CFG_W-1:0]   repeat_interval,
    output entry_t             new_entry
);

    logic [TIME_W-1:0] base_time;
    logic [CFG_W-1:0]  threshold;
    logic [TIME_W-1:0] elapsed;
    logic              due;
    flags_t            f;

    // one subtract serves both the initial delay and the repeat interval
    assign base_time = cur_entry.flags.repeating ? cur_entry.typed_time : cur_entry.change_time;
    assign threshold = cur_entry.flags.repeating ? repeat_interval : repeat_delay;
    assign elapsed   = now - base_time;
    assign due       = elapsed >= {{(TIME_W-CFG_W){1'b0}}, threshold};
    assign f         = cur_entry.flags;

    always_comb begin
        new_entry = cur_entry;
        if (!is_tick) begin
            new_entry.flags            = '0;
            new_entry.flags.type_pulse = f.type_pulse;
            new_entry.flags.down       = level;
            new_entry.flags.changed    = level != f.down;
            new_entry.change_time      = now;
        end else if (!f.down) begin
            new_entry.flags = '0;
        end else begin
            priority if (f.type_pulse) begin
                // pulse lasts one frame
                new_entry.flags.type_pulse = 1'b0;
            end else if (f.changed) begin
                new_entry.flags.repeating  = 1'b0;
                new_entry.flags.type_pulse = 1'b1;
                new_entry.typed_time       = now;
            end else if (due) begin
                new_entry.flags.repeating  = 1'b1;
                new_entry.flags.type_pulse = 1'b1;
                new_entry.typed_time       = now;
            end else begin
                // not due yet: hold without a pulse
                new_entry.flags.type_pulse = 1'b0;
            end
            new_entry.flags.changed = 1'b0;
        end
    end

endmodule

// ----- rtl/key_autorepeat_table.sv -----
// Key event, query and idle op: the entry is read on accept, used in ACCESS, and the result
// moves to the output register from DONE. Frame-end tick: one key per cycle through
// the table memory (read key k+1 while writing back key k), then DONE as above.
// One item in flight; a new item is taken once the result has moved to the output register.
// Reset (aresetn low, synchronous) clears all key flags through per-entry valid bits and
// loads delay 400 ms, interval 16 ms; no clearing pass is needed.
module key_autorepeat_table
    import kat_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [7:0]         s_key_index,
    input  logic               s_pressed,
    input  logic [TIME_W-1:0]  s_time_ms,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_key_down,
    output logic               m_key_pressed,
    output logic               m_key_released,
    output logic               m_should_type,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ACCESS = 4'b0010,
        ST_SWEEP  = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               in_range_reg, in_range_next;
    logic               level_reg, level_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [KEY_W-1:0]   proc_reg, proc_next;
    result_t            res_reg, res_next;
    result_t            out_reg, out_next;
    logic               m_valid_reg, m_valid_next;
    logic [CFG_W-1:0]   delay_reg, interval_reg;

    entry_t             mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] valid_reg;
    entry_t             rd_entry_reg;
    logic               rd_vld_reg;
    logic               rd_en, we;
    logic [KEY_W-1:0]   rd_addr, wr_addr;
    entry_t             cur_entry, new_entry;
    logic               accept;

    assign s_ready   = state_reg == ST_IDLE;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // never-written entries read as cleared flags
    always_comb begin
        cur_entry = rd_entry_reg;
        if (!rd_vld_reg) begin
            cur_entry.flags = '0;
        end
    end

    kat_entry_update u_update (
        .cur_entry       (cur_entry),
        .is_tick         (op_reg == OP_TICK),
        .level           (level_reg),
        .now             (now_reg),
        .repeat_delay    (delay_reg),
        .repeat_interval (interval_reg),
        .new_entry       (new_entry)
    );

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        in_range_next = in_range_reg;
        level_next    = level_reg;
        now_next      = now_reg;
        proc_next     = proc_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        rd_en         = 1'b0;
        rd_addr       = KEY_W'(s_key_index);
        we            = 1'b0;
        wr_addr       = key_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next       = op_t'(s_op);
                    key_next      = KEY_W'(s_key_index);
                    in_range_next = int'(s_key_index) < NUM_KEYS;
                    level_next    = s_pressed;
                    now_next      = s_time_ms;
                    proc_next     = '0;
                    rd_en         = 1'b1;
                    if (op_t'(s_op) == OP_TICK) begin
                        rd_addr    = '0;
                        state_next = ST_SWEEP;
                    end else begin
                        state_next = ST_ACCESS;
                    end
                end
            end
            ST_ACCESS: begin
                res_next = '0;
                if (in_range_reg && op_reg == OP_QUERY) begin
                    res_next.key_down     = cur_entry.flags.down;
                    res_next.key_pressed  = cur_entry.flags.down && cur_entry.flags.changed;
                    res_next.key_released = !cur_entry.flags.down && cur_entry.flags.changed;
                    res_next.should_type  = cur_entry.flags.type_pulse;
                end
                we         = in_range_reg && op_reg == OP_EVENT;
                state_next = ST_DONE;
            end
            ST_SWEEP: begin
                we       = 1'b1;
                wr_addr  = proc_reg;
                res_next = '0;
                if (proc_reg == LAST_KEY) begin
                    state_next = ST_DONE;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = proc_reg + 1'b1;
                    proc_next = proc_reg + 1'b1;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= new_entry;
        end
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            delay_reg    <= DELAY_RESET;
            interval_reg <= INTERVAL_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DELAY) begin
                    delay_reg <= cfg_data;
                end else if (cfg_index == REG_INTERVAL) begin
                    interval_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        in_range_reg <= in_range_next;
        level_reg    <= level_next;
        now_reg      <= now_next;
        proc_reg     <= proc_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_key_down     = out_reg.key_down;
    assign m_key_pressed  = out_reg.key_pressed;
    assign m_key_released = out_reg.key_released;
    assign m_should_type  = out_reg.should_type;

    a_write_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (state_reg == ST_ACCESS || state_reg == ST_SWEEP))
        else $error("table write outside access or sweep");

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (we && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same entry");

    a_sweep_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && proc_reg != LAST_KEY) |=>
            (state_reg == ST_SWEEP && proc_reg == $past(proc_reg) + 1'b1))
        else $error("sweep skipped or stalled");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg ##1 m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside done state");

    a_accept_idle_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACCESS || state_reg == ST_SWEEP) |-> !s_ready)
        else $error("input taken while busy");

endmodule

// ----- tb/tb_key_autorepeat_table.sv -----
`timescale 1ns / 100ps

module tb_key_autorepeat_table;
    import kat_pkg::*;

    localparam int unsigned LIMIT = 3_000_000;

    // Tracks the key table and queues the answer each accepted item must produce.
    class repeat_answer_board;
        flags_t            flags     [NUM_KEYS];
        logic [TIME_W-1:0] change_ms [NUM_KEYS];
        logic [TIME_W-1:0] typed_ms  [NUM_KEYS];
        logic [CFG_W-1:0]  delay_ms;
        logic [CFG_W-1:0]  interval_ms;
        result_t           expected_answers [$];
        int n_checked, n_errors, n_ticks, n_queries, n_pulses, n_press_edges, n_release_edges;

        function new();
            foreach (flags[k]) begin
                flags[k]     = '0;
                change_ms[k] = '0;
                typed_ms[k]  = '0;
            end
            delay_ms    = DELAY_RESET;
            interval_ms = INTERVAL_RESET;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_DELAY:    delay_ms    = val;
                REG_INTERVAL: interval_ms = val;
                default: ;
            endcase
        endfunction

        // Walk every key at frame end; differences wrap modulo 2^32.
        function void advance_frame(logic [TIME_W-1:0] now);
            flags_t            f;
            logic [TIME_W-1:0] held;
            for (int k = 0; k < NUM_KEYS; k++) begin
                f = flags[k];
                if (!f.down) begin
                    flags[k] = '0;
                end else begin
                    if (f.type_pulse) begin
                        f.type_pulse = 1'b0;
                    end else if (f.changed) begin
                        f.repeating  = 1'b0;
                        f.type_pulse = 1'b1;
                        typed_ms[k]  = now;
                    end else if (!f.repeating) begin
                        held = now - change_ms[k];
                        if (held >= TIME_W'(delay_ms)) begin
                            f.repeating  = 1'b1;
                            f.type_pulse = 1'b1;
                            typed_ms[k]  = now;
                        end
                    end else begin
                        held = now - typed_ms[k];
                        if (held >= TIME_W'(interval_ms)) begin
                            f.type_pulse = 1'b1;
                            typed_ms[k]  = now;
                        end
                    end
                    f.changed = 1'b0;
                    flags[k]  = f;
                end
            end
        endfunction

        function void accept_item(op_t op, logic [7:0] key, logic level,
                                  logic [TIME_W-1:0] now);
            result_t answer;
            flags_t  f;
            flags_t  nf;
            answer = '0;
            case (op)
                OP_EVENT: begin
                    if (key < NUM_KEYS) begin
                        f             = flags[key];
                        nf            = '0;
                        nf.type_pulse = f.type_pulse;
                        nf.down       = level;
                        nf.changed    = (level != f.down);
                        flags[key]    = nf;
                        change_ms[key] = now;
                    end
                end
                OP_TICK: begin
                    n_ticks++;
                    advance_frame(now);
                end
                OP_QUERY: begin
                    n_queries++;
                    if (key < NUM_KEYS) begin
                        f                   = flags[key];
                        answer.key_down     = f.down;
                        answer.key_pressed  = f.down && f.changed;
                        answer.key_released = !f.down && f.changed;
                        answer.should_type  = f.type_pulse;
                        n_pulses        += answer.should_type;
                        n_press_edges   += answer.key_pressed;
                        n_release_edges += answer.key_released;
                    end
                end
                default: ;
            endcase
            expected_answers.push_back(answer);
        endfunction

        task report(string msg);
            n_errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_answer(result_t got);
            string   names [4] = '{"should_type", "key_released", "key_pressed", "key_down"};
            result_t want;
            if (expected_answers.size() == 0) begin
                report($sformatf("answer %b arrived with no item pending", got));
                return;
            end
            want = expected_answers.pop_front();
            n_checked++;
            for (int b = 3; b >= 0; b--) begin
                if (got[b] !== want[b])
                    report($sformatf("answer %0d: %s got %b want %b",
                                     n_checked, names[b], got[b], want[b]));
            end
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_op;
    logic [7:0]         s_key_index;
    logic               s_pressed;
    logic [TIME_W-1:0]  s_time_ms;
    logic               m_valid;
    logic               m_ready;
    logic               m_key_down;
    logic               m_key_pressed;
    logic               m_key_released;
    logic               m_should_type;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    repeat_answer_board answers = new();

    int                 burst_left;
    int                 n_sent;
    int                 n_writes;
    int unsigned        n_cycles = 0;
    logic [TIME_W-1:0]  now_ms;

    key_autorepeat_table i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_key_index    (s_key_index),
        .s_pressed      (s_pressed),
        .s_time_ms      (s_time_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_down     (m_key_down),
        .m_key_pressed  (m_key_pressed),
        .m_key_released (m_key_released),
        .m_should_type  (m_should_type),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     n_cycles, answers.expected_answers.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            answers.check_answer({m_key_down, m_key_pressed, m_key_released, m_should_type});
    end

    // Receiver: stall pattern changes at random, plus one long hold-off.
    initial begin
        int mode;
        bit held_off;
        m_ready  = 1'b0;
        mode     = 0;
        held_off = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!held_off && answers.n_checked >= 400) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (600) @(negedge aclk);
            end
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_item(op_t op, logic [7:0] key, logic level, logic [TIME_W-1:0] t_ms);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_op        <= op;
        s_key_index <= key;
        s_pressed   <= level;
        s_time_ms   <= t_ms;
        do @(posedge aclk); while (!s_ready);
        answers.accept_item(op, key, level, t_ms);
        n_sent++;
    endtask

    // Drop valid and wait until every queued answer has come back.
    task automatic drain_answers();
        @(negedge aclk);
        s_valid   <= 1'b0;
        burst_left = 0;
        while (answers.expected_answers.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        answers.set_reg(idx, val);
        n_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Press a few keys, run frames with queries and stray events, release all.
    task automatic play_sequence();
        logic [7:0] held_keys [4];
        int         n_held;
        int         n_frames;
        int         n_q;
        int         pick;
        n_held = $urandom_range(1, 4);
        for (int i = 0; i < n_held; i++) begin
            case ($urandom_range(0, 5))
                0:       held_keys[i] = 8'd0;
                1:       held_keys[i] = 8'hFF;
                default: held_keys[i] = 8'($urandom);
            endcase
            send_item(OP_EVENT, held_keys[i], 1'b1, now_ms);
            now_ms += $urandom_range(0, 3);
        end
        n_frames = $urandom_range(4, 40);
        repeat (n_frames) begin
            pick = $urandom_range(0, 31);
            if (pick == 0)
                now_ms += $urandom;
            else if (pick < 16)
                now_ms += $urandom_range(0, answers.interval_ms + 2);
            else
                now_ms += $urandom_range(0, answers.delay_ms / 6 + answers.interval_ms / 2 + 3);
            send_item(OP_TICK, 8'($urandom), 1'($urandom), now_ms);
            n_q = $urandom_range(0, 3);
            repeat (n_q)
                send_item(OP_QUERY,
                          ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                      : held_keys[$urandom_range(0, n_held - 1)],
                          1'($urandom), $urandom);
            if ($urandom_range(0, 9) == 0)
                send_item(OP_EVENT, held_keys[$urandom_range(0, n_held - 1)], 1'($urandom),
                          now_ms);
            if ($urandom_range(0, 19) == 0)
                send_item(($urandom_range(0, 1) == 0) ? OP_NONE : OP_EVENT, 8'($urandom),
                          1'($urandom), $urandom);
        end
        for (int i = 0; i < n_held; i++)
            send_item(OP_EVENT, held_keys[i], 1'b0, now_ms);
        for (int i = 0; i < n_held; i++)
            send_item(OP_QUERY, held_keys[i], 1'($urandom), $urandom);
        now_ms += $urandom_range(0, 20);
        send_item(OP_TICK, 8'($urandom), 1'($urandom), now_ms);
        for (int i = 0; i < n_held; i++)
            send_item(OP_QUERY, held_keys[i], 1'($urandom), $urandom);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_op        = OP_EVENT;
        s_key_index = '0;
        s_pressed   = 1'b0;
        s_time_ms   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_DELAY;
        cfg_data    = '0;
        burst_left  = 0;
        n_sent      = 0;
        n_writes    = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, same-level event, idle op, fresh press, repeat, release.
        send_item(OP_QUERY, 8'd0,  1'b1, 32'hFFFF_FFFF);
        send_item(OP_EVENT, 8'd0,  1'b1, 32'd0);
        send_item(OP_EVENT, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 8'd0,  1'b0, 32'd0);
        send_item(OP_QUERY, 8'hFF, 1'b0, 32'd0);
        send_item(OP_EVENT, 8'hFF, 1'b1, 32'd5);
        send_item(OP_QUERY, 8'hFF, 1'b0, 32'd0);
        send_item(OP_NONE,  8'hFF, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_EVENT, 8'h80, 1'b0, 32'h5555_AAAA);
        send_item(OP_TICK,  8'hFF, 1'b1, 32'd10);
        send_item(OP_QUERY, 8'd0,  1'b0, 32'd0);
        send_item(OP_TICK,  8'd0,  1'b0, 32'd20);
        send_item(OP_QUERY, 8'd0,  1'b0, 32'd0);
        send_item(OP_TICK,  8'd0,  1'b0, 32'd400);
        send_item(OP_QUERY, 8'd0,  1'b0, 32'd0);
        send_item(OP_TICK,  8'd0,  1'b0, 32'd415);
        send_item(OP_TICK,  8'd0,  1'b0, 32'd431);
        send_item(OP_QUERY, 8'd0,  1'b0, 32'd0);
        send_item(OP_EVENT, 8'd0,  1'b0, 32'd432);
        send_item(OP_QUERY, 8'd0,  1'b0, 32'd0);
        send_item(OP_TICK,  8'd0,  1'b0, 32'd440);
        send_item(OP_QUERY, 8'd0,  1'b0, 32'd0);
        send_item(OP_QUERY, 8'hFF, 1'b0, 32'd0);

        for (int phase = 0; phase < 7; phase++) begin
            if (phase != 0) begin
                drain_answers();
                case (phase)
                    1: begin
                        write_reg(REG_DELAY, '0);
                        write_reg(REG_INTERVAL, '0);
                    end
                    2: begin
                        write_reg(REG_INTERVAL, '1);
                        write_reg(REG_DELAY, '1);
                    end
                    3: begin
                        write_reg(REG_DELAY, CFG_W'(25));
                        write_reg(REG_INTERVAL, CFG_W'(4));
                    end
                    4: begin
                        write_reg(REG_DELAY, DELAY_RESET);
                        write_reg(REG_INTERVAL, INTERVAL_RESET);
                    end
                    5: begin
                        write_reg(REG_DELAY, CFG_W'($urandom_range(0, 600)));
                        write_reg(REG_INTERVAL, CFG_W'($urandom_range(0, 40)));
                    end
                    default: begin
                        write_reg(REG_DELAY, CFG_W'($urandom));
                        write_reg(REG_INTERVAL, CFG_W'($urandom));
                    end
                endcase
            end
            // Start some phases just short of the wrap.
            now_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                                 : $urandom;
            while (n_sent < 25 + 250 * (phase + 1))
                play_sequence();
        end

        drain_answers();
        repeat (300) @(posedge aclk);

        $display("run covered %0d items over 7 register settings (%0d writes): %0d frame ticks,",
                 n_sent, n_writes, answers.n_ticks);
        $display("%0d queries with %0d type pulses, %0d press and %0d release edges; %0d mismatches",
                 answers.n_queries, answers.n_pulses, answers.n_press_edges,
                 answers.n_release_edges, answers.n_errors);
        if (answers.n_errors == 0 && answers.expected_answers.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- key_autorepeat_table.f -----
rtl/kat_pkg.sv
rtl/kat_entry_update.sv
rtl/key_autorepeat_table.sv
tb/tb_key_autorepeat_table.sv
